@@ hdl/gms_pkg.sv @@
// Shared types, constants and helpers for the generative melody sequencer.
// No dependencies; every other file refers to this package by scoped names.
package gms_pkg;

  localparam int MAX_ONSETS = 5;
  localparam int SCALE_BITS = 5;

  localparam int CNT_W   = $clog2(MAX_ONSETS + 1);
  localparam int IDX_W   = $clog2(MAX_ONSETS);
  localparam int HDEG_W  = SCALE_BITS + 1;
  localparam int DEG_W   = SCALE_BITS + 2;
  localparam int SDEG_W  = SCALE_BITS + 4;
  localparam int POS_W   = 4;
  localparam int LEN_W   = 5;
  localparam int KIND_W  = 2;
  localparam int NOTE_W  = 3;
  localparam int BAR_W   = 2;
  localparam int PHRASE_W = 2;
  localparam int RNG_W   = 32;
  localparam int REM_W   = 4;
  localparam int NIB_N   = RNG_W / 4;
  localparam int NIB_W   = $clog2(NIB_N);

  localparam logic [RNG_W-1:0] SEED_RESET = 32'd2463534242;

  localparam int XS_SHL_A = 13;
  localparam int XS_SHR   = 17;
  localparam int XS_SHL_B = 5;

  localparam int GAP_N = 6;
  localparam logic [2:0] GAP_TABLE [0:GAP_N-1] = '{3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4};

  localparam logic [REM_W-1:0] MOD_GAP_VAL   = REM_W'(GAP_N);
  localparam logic [REM_W-1:0] MOD_BIT_VAL   = 4'd2;
  localparam logic [REM_W-1:0] MOD_SHIFT_VAL = 4'd3;
  localparam logic [REM_W-1:0] MOD_SLIDE_VAL = 4'd10;

  localparam int POS_LIMIT    = 13;
  localparam int SLIDE_LIMIT  = 6;
  localparam int RUN_END      = 7;
  localparam int RUN_OFFSET   = 5;
  localparam int REST_LEN     = 4;
  localparam int PICKUP_LEN   = 4;
  localparam int RESOLVE_LEN  = 12;
  localparam int RUN_LEN      = 2;
  localparam int BAR_STEPS    = 16;
  localparam int MIN_SCALE    = 2;
  localparam int MAX_DEGREE   = 3 * ((1 << SCALE_BITS) - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_REST   = 2'd0,
    KIND_ATTACK = 2'd1,
    KIND_SLIDE  = 2'd2
  } note_kind_t;

  typedef enum logic [1:0] {
    MOD_GAP,
    MOD_BIT,
    MOD_SHIFT,
    MOD_SLIDE
  } mod_sel_t;

  typedef struct packed {
    logic     start;
    mod_sel_t sel;
  } draw_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } draw_rsp_t;

  function automatic logic [REM_W-1:0] modulus(input mod_sel_t sel);
    logic [REM_W-1:0] m;
    case (sel)
      MOD_GAP:   m = MOD_GAP_VAL;
      MOD_BIT:   m = MOD_BIT_VAL;
      MOD_SHIFT: m = MOD_SHIFT_VAL;
      MOD_SLIDE: m = MOD_SLIDE_VAL;
      default:   m = MOD_BIT_VAL;
    endcase
    return m;
  endfunction

  function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] s_in);
    logic [RNG_W-1:0] s;
    s = s_in;
    s = s ^ (s << XS_SHL_A);
    s = s ^ (s >> XS_SHR);
    s = s ^ (s << XS_SHL_B);
    return s;
  endfunction

endpackage

@@ hdl/gms_if.sv @@
// Valid/ready channel interfaces for the melody sequencer: request and note result.
// Depends on gms_pkg for field widths.
interface gms_in_if;
  logic                           valid;
  logic                           ready;
  logic [gms_pkg::SCALE_BITS-1:0] scale_len;

  modport source (output valid, output scale_len, input ready);
  modport sink   (input valid, input scale_len, output ready);
endinterface

interface gms_out_if;
  logic                       valid;
  logic                       ready;
  logic [gms_pkg::KIND_W-1:0] note_kind;
  logic [gms_pkg::DEG_W-1:0]  degree;
  logic [gms_pkg::LEN_W-1:0]  length_16ths;

  modport source (output valid, output note_kind, output degree, output length_16ths,
                  input ready);
  modport sink   (input valid, input note_kind, input degree, input length_16ths,
                  output ready);
endinterface

@@ hdl/gms_draw.sv @@
// Shared random draw unit: xorshift generator plus a nibble-serial small-modulus reducer.
// Depends on gms_pkg (xorshift, modulus table, request/response structs).
module gms_draw (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        seed_load,
  input  logic [gms_pkg::RNG_W-1:0]   seed_value,
  input  gms_pkg::draw_req_t          req,
  output gms_pkg::draw_rsp_t          rsp
);

  logic [gms_pkg::RNG_W-1:0] rng_r, rng_nxt;
  logic [gms_pkg::RNG_W-1:0] word_r, word_nxt;
  logic [gms_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [gms_pkg::REM_W-1:0] mod_r, mod_nxt;
  logic [gms_pkg::NIB_W-1:0] nib_r, nib_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [gms_pkg::RNG_W-1:0] fresh;
  logic [7:0]                red;
  logic [7:0]                msh;

  always_comb begin
    fresh = gms_pkg::xorshift(rng_r);
    // Restoring reduction of {rem, next nibble}, which stays below 16 * modulus.
    red = {rem_r, word_r[gms_pkg::RNG_W-1 -: 4]};
    for (int i = 3; i >= 0; i--) begin
      msh = 8'({4'b0, mod_r} << i);
      if (red >= msh) begin
        red = red - msh;
      end
    end

    rng_nxt  = rng_r;
    word_nxt = word_r;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    nib_nxt  = nib_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (seed_load) begin
      rng_nxt = seed_value;
    end else if (req.start) begin
      rng_nxt  = fresh;
      word_nxt = fresh;
      rem_nxt  = '0;
      mod_nxt  = gms_pkg::modulus(req.sel);
      nib_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      word_nxt = word_r << 4;
      rem_nxt  = red[gms_pkg::REM_W-1:0];
      nib_nxt  = nib_r + 1'b1;
      if (nib_r == gms_pkg::NIB_W'(gms_pkg::NIB_N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r  <= gms_pkg::SEED_RESET;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      nib_r  <= '0;
    end else begin
      rng_r  <= rng_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      nib_r  <= nib_nxt;
    end
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
    mod_r  <= mod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ hdl/generative_melody_sequencer.sv @@
// Top level of the generative melody sequencer: note sequencer FSM, hook store, output register.
// Depends on gms_pkg, gms_if.sv (channel interfaces) and gms_draw (shared random draw unit).
//
// Each transfer on the request channel (scale_len, raised to at least 2) yields exactly one
// note on the result channel: kind (rest/attack/slide), scale degree and length in sixteenths.
// Melody sections of four phrases of four bars: bar 0 plays a random hook, bar 1 repeats it
// shifted by -1/0/+1, bar 2 is a two-note resolution, bar 3 a rest plus a six-note run; the
// third phrase of each section is lifted by one scale length. All randomness comes from a
// 32-bit xorshift generator; writing cfg_wr_data with cfg_wr_en loads the seed straight into
// the generator (reset seed 2463534242). One request is handled at a time: in_if.ready is high
// only while the sequencer is idle, and a finished note waits in the output register so the
// next request can transfer meanwhile. Every random choice goes through one shared draw unit
// whose registered result follows one generator step and then a remainder reduced four bits
// per cycle across the word, a seed load pausing it. Resolution and run notes and the first
// note of bar 1 need no draw; the other hook and answer notes need one draw (the slide
// choice, or the answer shift on the first note of bar 0); the first note of each section
// also rolls a new hook, which adds up to 11 draws. A stalled result channel, with a note
// still in the output register, holds the new note in S_EMIT and delays the return to idle.
module generative_melody_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  gms_in_if.sink                    in_if,
  gms_out_if.source                 out_if,
  input  logic                      cfg_wr_en,
  input  logic [gms_pkg::RNG_W-1:0] cfg_wr_data
);

  localparam int SW = gms_pkg::SDEG_W;

  localparam logic [gms_pkg::BAR_W-1:0] BAR_HOOK    = 2'd0;
  localparam logic [gms_pkg::BAR_W-1:0] BAR_ANSWER  = 2'd1;
  localparam logic [gms_pkg::BAR_W-1:0] BAR_RESOLVE = 2'd2;
  localparam logic [gms_pkg::BAR_W-1:0] BAR_RUN     = 2'd3;
  localparam logic [gms_pkg::PHRASE_W-1:0] PHRASE_LIFT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROLL_POS,
    S_ROLL_GAP,
    S_ROLL_D0,
    S_ROLL_DEG,
    S_ROLL_STEP,
    S_NOTE,
    S_SHIFT,
    S_READ0,
    S_READ1,
    S_KIND,
    S_EMIT
  } state_t;

  function automatic logic signed [SW-1:0] clamp_deg(input logic signed [SW-1:0] v,
                                                     input logic signed [SW-1:0] hi);
    logic signed [SW-1:0] r;
    r = v;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // Control state
  state_t                          state_r, state_nxt;
  logic [gms_pkg::SCALE_BITS-1:0]  sl_r, sl_nxt;
  logic [gms_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [gms_pkg::CNT_W-1:0]       hix_r, hix_nxt;
  logic [gms_pkg::POS_W:0]         pos_r, pos_nxt;
  logic signed [SW-1:0]            d_r, d_nxt;
  logic [1:0]                      shift_r, shift_nxt;
  logic [gms_pkg::BAR_W-1:0]       bar_r, bar_nxt;
  logic [gms_pkg::NOTE_W-1:0]      idx_r, idx_nxt;
  logic [gms_pkg::PHRASE_W-1:0]    phrase_r, phrase_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // Payload
  logic [gms_pkg::POS_W-1:0]       at_r, at_nxt;
  logic [gms_pkg::HDEG_W-1:0]      base_r, base_nxt;
  gms_pkg::note_kind_t             res_kind_r, res_kind_nxt;
  logic [gms_pkg::DEG_W-1:0]       res_deg_r, res_deg_nxt;
  logic [gms_pkg::LEN_W-1:0]       res_len_r, res_len_nxt;
  gms_pkg::note_kind_t             out_kind_r, out_kind_nxt;
  logic [gms_pkg::DEG_W-1:0]       out_deg_r, out_deg_nxt;
  logic [gms_pkg::LEN_W-1:0]       out_len_r, out_len_nxt;

  // Hook store
  logic [gms_pkg::POS_W-1:0]       onset_pos_r [gms_pkg::MAX_ONSETS];
  logic [gms_pkg::HDEG_W-1:0]      hook_deg_r  [gms_pkg::MAX_ONSETS];
  logic                            pos_we, hdeg_we;
  logic [gms_pkg::IDX_W-1:0]       pos_waddr, hdeg_waddr;
  logic [gms_pkg::POS_W-1:0]       pos_wdata;
  logic [gms_pkg::HDEG_W-1:0]      hdeg_wdata;

  // Read port of the hook store
  logic [gms_pkg::CNT_W-1:0]       rd_sel;
  logic                            rd_hit;
  logic [gms_pkg::POS_W-1:0]       rd_pos;
  logic [gms_pkg::HDEG_W-1:0]      rd_deg;

  gms_pkg::draw_req_t              draw_req;
  gms_pkg::draw_rsp_t              draw_rsp;

  // Working values
  logic [gms_pkg::SCALE_BITS-1:0]  in_sl;
  logic signed [SW-1:0]            sl_s, lift_s, hi_s, k_s, shift_s, deg_s;
  logic [gms_pkg::POS_W:0]         next_at;
  logic [gms_pkg::NOTE_W-1:0]      idx_inc;
  logic                            hook_wrap;

  gms_draw u_draw (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed_load  (cfg_wr_en),
    .seed_value (cfg_wr_data),
    .req        (draw_req),
    .rsp        (draw_rsp)
  );

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.note_kind    = out_kind_r;
  assign out_if.degree       = out_deg_r;
  assign out_if.length_16ths = out_len_r;

  // Single read port; read the next onset in the second read cycle.
  always_comb begin
    rd_sel = gms_pkg::CNT_W'(idx_r);
    if (state_r == S_READ1) begin
      rd_sel = gms_pkg::CNT_W'(idx_r) + 1'b1;
    end
    rd_hit = (rd_sel < cnt_r);
    rd_pos = rd_hit ? onset_pos_r[rd_sel[gms_pkg::IDX_W-1:0]] : '0;
    rd_deg = rd_hit ? hook_deg_r[rd_sel[gms_pkg::IDX_W-1:0]] : '0;
  end

  always_comb begin
    in_sl   = (in_if.scale_len < gms_pkg::SCALE_BITS'(gms_pkg::MIN_SCALE)) ?
              gms_pkg::SCALE_BITS'(gms_pkg::MIN_SCALE) : in_if.scale_len;
    sl_s    = SW'(sl_r);
    lift_s  = (phrase_r == PHRASE_LIFT) ? sl_s : '0;
    hi_s    = sl_s + sl_s + sl_s;
    k_s     = SW'(idx_r) - SW'(1);
    shift_s = SW'(signed'(shift_r));
    next_at = rd_hit ? {1'b0, rd_pos} : (gms_pkg::POS_W + 1)'(gms_pkg::BAR_STEPS);
    // Advance within the hook bars; wrap to the next bar after the last onset.
    idx_inc   = idx_r + 1'b1;
    hook_wrap = ((gms_pkg::NOTE_W + 1)'(idx_inc) >= (gms_pkg::NOTE_W + 1)'(cnt_r));
    deg_s   = '0;

    state_nxt     = state_r;
    sl_nxt        = sl_r;
    cnt_nxt       = cnt_r;
    hix_nxt       = hix_r;
    pos_nxt       = pos_r;
    d_nxt         = d_r;
    shift_nxt     = shift_r;
    bar_nxt       = bar_r;
    idx_nxt       = idx_r;
    phrase_nxt    = phrase_r;
    out_valid_nxt = out_valid_r;
    at_nxt        = at_r;
    base_nxt      = base_r;
    res_kind_nxt  = res_kind_r;
    res_deg_nxt   = res_deg_r;
    res_len_nxt   = res_len_r;
    out_kind_nxt  = out_kind_r;
    out_deg_nxt   = out_deg_r;
    out_len_nxt   = out_len_r;

    draw_req.start = 1'b0;
    draw_req.sel   = gms_pkg::MOD_BIT;
    pos_we     = 1'b0;
    pos_waddr  = cnt_r[gms_pkg::IDX_W-1:0];
    pos_wdata  = pos_r[gms_pkg::POS_W-1:0];
    hdeg_we    = 1'b0;
    hdeg_waddr = hix_r[gms_pkg::IDX_W-1:0];
    hdeg_wdata = gms_pkg::HDEG_W'(clamp_deg(d_r, sl_s + sl_s));

    // Drop the result once the sink takes it.
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          sl_nxt = in_sl;
          if (cnt_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_ROLL_POS;
          end else begin
            state_nxt = S_NOTE;
          end
        end
      end

      // Hook roll: store onset, then draw a gap.
      S_ROLL_POS: begin
        pos_we         = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        draw_req.start = 1'b1;
        draw_req.sel   = gms_pkg::MOD_GAP;
        state_nxt      = S_ROLL_GAP;
      end

      S_ROLL_GAP: begin
        if (draw_rsp.done) begin
          pos_nxt = pos_r + (gms_pkg::POS_W + 1)'(gms_pkg::GAP_TABLE[draw_rsp.rem[2:0]]);
          if (cnt_r == gms_pkg::CNT_W'(gms_pkg::MAX_ONSETS) ||
              pos_nxt > (gms_pkg::POS_W + 1)'(gms_pkg::POS_LIMIT)) begin
            draw_req.start = 1'b1;
            draw_req.sel   = gms_pkg::MOD_BIT;
            state_nxt      = S_ROLL_D0;
          end else begin
            state_nxt = S_ROLL_POS;
          end
        end
      end

      S_ROLL_D0: begin
        if (draw_rsp.done) begin
          d_nxt     = sl_s - SW'(draw_rsp.rem);
          hix_nxt   = '0;
          state_nxt = S_ROLL_DEG;
        end
      end

      S_ROLL_DEG: begin
        hdeg_we        = 1'b1;
        draw_req.start = 1'b1;
        draw_req.sel   = gms_pkg::MOD_BIT;
        state_nxt      = S_ROLL_STEP;
      end

      S_ROLL_STEP: begin
        if (draw_rsp.done) begin
          d_nxt   = d_r + SW'(1) + SW'(draw_rsp.rem);
          hix_nxt = hix_r + 1'b1;
          state_nxt = (hix_nxt == cnt_r) ? S_NOTE : S_ROLL_DEG;
        end
      end

      S_NOTE: begin
        case (bar_r)
          BAR_RUN: begin
            if (idx_r == '0) begin
              res_kind_nxt = gms_pkg::KIND_REST;
              deg_s        = sl_s + lift_s;
              res_len_nxt  = gms_pkg::LEN_W'(gms_pkg::REST_LEN);
              idx_nxt      = gms_pkg::NOTE_W'(1);
            end else begin
              deg_s = phrase_r[0] ? (sl_s + sl_s - k_s - k_s)
                                  : (sl_s - SW'(gms_pkg::RUN_OFFSET) + k_s);
              deg_s        = clamp_deg(deg_s, hi_s);
              res_len_nxt  = gms_pkg::LEN_W'(gms_pkg::RUN_LEN);
              res_kind_nxt = (idx_r == gms_pkg::NOTE_W'(1)) ? gms_pkg::KIND_ATTACK
                                                            : gms_pkg::KIND_SLIDE;
              idx_nxt      = idx_inc;
              if (idx_inc >= gms_pkg::NOTE_W'(gms_pkg::RUN_END)) begin
                // End of phrase; a new section rolls a fresh hook.
                idx_nxt    = '0;
                bar_nxt    = BAR_HOOK;
                phrase_nxt = phrase_r + 1'b1;
                if (phrase_nxt == '0) begin
                  cnt_nxt = '0;
                end
              end
            end
            res_deg_nxt = deg_s[gms_pkg::DEG_W-1:0];
            state_nxt   = S_EMIT;
          end
          BAR_RESOLVE: begin
            if (idx_r == '0) begin
              res_kind_nxt = gms_pkg::KIND_ATTACK;
              deg_s        = sl_s + lift_s + SW'(1);
              res_len_nxt  = gms_pkg::LEN_W'(gms_pkg::PICKUP_LEN);
              idx_nxt      = gms_pkg::NOTE_W'(1);
            end else begin
              res_kind_nxt = gms_pkg::KIND_SLIDE;
              deg_s        = sl_s + lift_s;
              res_len_nxt  = gms_pkg::LEN_W'(gms_pkg::RESOLVE_LEN);
              idx_nxt      = '0;
              bar_nxt      = BAR_RUN;
            end
            res_deg_nxt = deg_s[gms_pkg::DEG_W-1:0];
            state_nxt   = S_EMIT;
          end
          default: begin
            if (bar_r == BAR_HOOK && idx_r == '0) begin
              draw_req.start = 1'b1;
              draw_req.sel   = gms_pkg::MOD_SHIFT;
              state_nxt      = S_SHIFT;
            end else begin
              state_nxt = S_READ0;
            end
          end
        endcase
      end

      S_SHIFT: begin
        if (draw_rsp.done) begin
          shift_nxt = draw_rsp.rem[1:0] - 2'd1;
          state_nxt = S_READ0;
        end
      end

      S_READ0: begin
        at_nxt    = rd_pos;
        base_nxt  = rd_deg;
        state_nxt = S_READ1;
      end

      S_READ1: begin
        deg_s = SW'(base_r) + lift_s + ((bar_r == BAR_ANSWER) ? shift_s : '0);
        deg_s = clamp_deg(deg_s, hi_s);
        res_deg_nxt = deg_s[gms_pkg::DEG_W-1:0];
        res_len_nxt = gms_pkg::LEN_W'(next_at - (gms_pkg::POS_W + 1)'(at_r));
        if (idx_r == '0) begin
          res_kind_nxt = gms_pkg::KIND_ATTACK;
          idx_nxt      = hook_wrap ? '0 : idx_inc;
          bar_nxt      = hook_wrap ? bar_r + 1'b1 : bar_r;
          state_nxt    = S_EMIT;
        end else begin
          draw_req.start = 1'b1;
          draw_req.sel   = gms_pkg::MOD_SLIDE;
          state_nxt      = S_KIND;
        end
      end

      S_KIND: begin
        if (draw_rsp.done) begin
          res_kind_nxt = (draw_rsp.rem < gms_pkg::REM_W'(gms_pkg::SLIDE_LIMIT)) ?
                         gms_pkg::KIND_SLIDE : gms_pkg::KIND_ATTACK;
          idx_nxt      = hook_wrap ? '0 : idx_inc;
          bar_nxt      = hook_wrap ? bar_r + 1'b1 : bar_r;
          state_nxt    = S_EMIT;
        end
      end

      // Hold the note until the output register is free.
      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_deg_nxt   = res_deg_r;
          out_len_nxt   = res_len_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hix_r       <= '0;
      shift_r     <= '0;
      bar_r       <= BAR_HOOK;
      idx_r       <= '0;
      phrase_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hix_r       <= hix_nxt;
      shift_r     <= shift_nxt;
      bar_r       <= bar_nxt;
      idx_r       <= idx_nxt;
      phrase_r    <= phrase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sl_r       <= sl_nxt;
    pos_r      <= pos_nxt;
    d_r        <= d_nxt;
    at_r       <= at_nxt;
    base_r     <= base_nxt;
    res_kind_r <= res_kind_nxt;
    res_deg_r  <= res_deg_nxt;
    res_len_r  <= res_len_nxt;
    out_kind_r <= out_kind_nxt;
    out_deg_r  <= out_deg_nxt;
    out_len_r  <= out_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      onset_pos_r[pos_waddr] <= pos_wdata;
    end
    if (hdeg_we) begin
      hook_deg_r[hdeg_waddr] <= hdeg_wdata;
    end
  end

endmodule

@@ hdl/gms_checker.sv @@
// Port-level assertions for the melody sequencer, bound to the top level.
// Depends on gms_pkg for codes and limits.
module gms_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gms_pkg::KIND_W-1:0]     note_kind,
  input logic [gms_pkg::DEG_W-1:0]      degree,
  input logic [gms_pkg::LEN_W-1:0]      length_16ths
);

  // One request at a time: a request transfer closes the input side.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a note was in progress");

  // A new note appears only as the sequencer returns to idle.
  a_ready_with_note: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("note presented while the sequencer is still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(note_kind) && $stable(degree) &&
                                $stable(length_16ths))
    else $error("stalled note changed or dropped");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> length_16ths != '0 &&
                  length_16ths <= gms_pkg::LEN_W'(gms_pkg::BAR_STEPS) &&
                  degree <= gms_pkg::DEG_W'(gms_pkg::MAX_DEGREE))
    else $error("note length or degree out of range");

  a_rest_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && note_kind == gms_pkg::KIND_REST |->
      length_16ths == gms_pkg::LEN_W'(gms_pkg::REST_LEN))
    else $error("rest with wrong length");

endmodule

bind generative_melody_sequencer gms_checker u_gms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .note_kind    (out_if.note_kind),
  .degree       (out_if.degree),
  .length_16ths (out_if.length_16ths)
);
